// ===== rtl/core/hims_pkg.sv =====
// Shared types of the hybrid insertion/merge sorter: datapath operations and status flags.
package hims_pkg;

    localparam int VALUE_W = 32;

    // One operation per cycle, issued by the controller to the datapath.
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_RUN_BEGIN,
        OP_RUN_ADVANCE,
        OP_INS_FETCH,
        OP_INS_HOLD,
        OP_INS_SHIFT,
        OP_INS_PLACE,
        OP_PASS_BEGIN,
        OP_PASS_ADVANCE,
        OP_MRG_BEGIN,
        OP_SEG_ADVANCE,
        OP_COPY_READ,
        OP_COPY_WRITE,
        OP_MRG_READ,
        OP_MRG_WRITE,
        OP_OUT_BEGIN,
        OP_OUT_READ,
        OP_OUT_NEXT,
        OP_OUT_DONE
    } dp_op_t;

    typedef struct packed {
        logic in_last;        // item on the input carries the end-of-batch mark
        logic start_below_n;  // run or segment start lies inside the batch
        logic ins_more;       // insertion index has not passed the run end
        logic greater;        // compared store entry is greater than the held value
        logic hole_edge;      // one more shift moves the hole to the run start
        logic pass_more;      // merge width is still below the batch size
        logic join_need;      // segment has a right half to merge
        logic k_at_hi;        // copy/merge pointer sits on the segment end
        logic out_last;       // output pointer sits on the final element
    } dp_status_t;

endpackage

// ===== rtl/core/hims_dp.sv =====
// Datapath of the sorter: element store, merge scratch memory, pointers and comparators.
module hims_dp
    import hims_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64,
    parameter int RUN_LENGTH   = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  dp_op_t             op,
    input  logic [VALUE_W-1:0] in_value,
    input  logic               in_last,
    output dp_status_t         status,
    output logic [VALUE_W-1:0] out_value,
    output logic               out_dropped
);

    localparam int AW   = $clog2(MAX_ELEMENTS);
    localparam int CNTW = $clog2(MAX_ELEMENTS + 1);
    // Positions must hold segment ends, which can reach about three times the capacity.
    localparam int CW   = $clog2(3 * MAX_ELEMENTS + RUN_LENGTH + 1);
    localparam logic [CW-1:0]   RUN_C = CW'(RUN_LENGTH);
    localparam logic [CW-1:0]   ONE_C = CW'(1);
    localparam logic [CW-1:0]   TWO_C = CW'(2);
    localparam logic [CNTW-1:0] CAP_C = CNTW'(MAX_ELEMENTS);

    logic [VALUE_W-1:0] store_mem   [MAX_ELEMENTS];
    logic [VALUE_W-1:0] scratch_mem [MAX_ELEMENTS];

    logic [CNTW-1:0]    count_reg, count_next;
    logic               overflow_reg, overflow_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      start_reg, start_next;
    logic [CW-1:0]      width_reg, width_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      hole_reg, hole_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [CW-1:0]      mid_reg, mid_next;
    logic [CW-1:0]      a_reg, a_next;
    logic [CW-1:0]      b_reg, b_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [VALUE_W-1:0] held_reg, held_next;
    logic [VALUE_W-1:0] store_rdata_reg;
    logic [VALUE_W-1:0] sa_reg;
    logic [VALUE_W-1:0] sb_reg;

    logic               st_we;
    logic [AW-1:0]      st_waddr;
    logic [VALUE_W-1:0] st_wdata;
    logic               st_re;
    logic [AW-1:0]      st_raddr;
    logic               sc_we;
    logic               sc_re;

    logic [CW-1:0]      hole_m1;
    logic [CW-1:0]      hole_m2;
    logic [CW-1:0]      n_m1;
    logic [CW-1:0]      run_end;
    logic [CW-1:0]      width_x2;
    logic [CW-1:0]      seg_end;
    logic               take_a;
    logic               has_room;

    assign hole_m1  = hole_reg - ONE_C;
    assign hole_m2  = hole_reg - TWO_C;
    assign n_m1     = n_reg - ONE_C;
    assign run_end  = start_reg + RUN_C - ONE_C;
    assign width_x2 = width_reg << 1;
    assign seg_end  = start_reg + width_x2 - ONE_C;
    assign has_room = count_reg < CAP_C;

    // The left head wins ties, which keeps the merge stable.
    assign take_a = (a_reg <= mid_reg) &&
                    ((b_reg > hi_reg) || !($signed(sa_reg) > $signed(sb_reg)));

    always_comb begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        n_next        = n_reg;
        start_next    = start_reg;
        width_next    = width_reg;
        i_next        = i_reg;
        hole_next     = hole_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        k_next        = k_reg;
        held_next     = held_reg;
        st_we         = 1'b0;
        st_waddr      = k_reg[AW-1:0];
        st_wdata      = store_rdata_reg;
        st_re         = 1'b0;
        st_raddr      = k_reg[AW-1:0];
        sc_we         = 1'b0;
        sc_re         = 1'b0;
        unique case (op)
            OP_IDLE: begin
            end
            OP_LOAD: begin
                start_next = '0;
                if (has_room) begin
                    st_we      = 1'b1;
                    st_waddr   = count_reg[AW-1:0];
                    st_wdata   = in_value;
                    count_next = count_reg + CNTW'(1);
                    n_next     = CW'(count_reg) + ONE_C;
                end else begin
                    overflow_next = 1'b1;
                    n_next        = CW'(count_reg);
                end
            end
            OP_RUN_BEGIN: begin
                hi_next = (run_end > n_m1) ? n_m1 : run_end;
                i_next  = start_reg + ONE_C;
            end
            OP_RUN_ADVANCE: begin
                start_next = start_reg + RUN_C;
            end
            OP_INS_FETCH: begin
                st_re     = 1'b1;
                st_raddr  = i_reg[AW-1:0];
                hole_next = i_reg;
            end
            OP_INS_HOLD: begin
                held_next = store_rdata_reg;
                st_re     = 1'b1;
                st_raddr  = hole_m1[AW-1:0];
            end
            OP_INS_SHIFT: begin
                st_we     = 1'b1;
                st_waddr  = hole_reg[AW-1:0];
                st_wdata  = store_rdata_reg;
                hole_next = hole_m1;
                st_re     = 1'b1;
                st_raddr  = hole_m2[AW-1:0];
            end
            OP_INS_PLACE: begin
                st_we    = 1'b1;
                st_waddr = hole_reg[AW-1:0];
                st_wdata = held_reg;
                i_next   = i_reg + ONE_C;
            end
            OP_PASS_BEGIN: begin
                width_next = RUN_C;
                start_next = '0;
            end
            OP_PASS_ADVANCE: begin
                width_next = width_x2;
                start_next = '0;
            end
            OP_MRG_BEGIN: begin
                mid_next = start_reg + width_reg - ONE_C;
                hi_next  = (seg_end > n_m1) ? n_m1 : seg_end;
                a_next   = start_reg;
                b_next   = start_reg + width_reg;
                k_next   = start_reg;
            end
            OP_SEG_ADVANCE: begin
                start_next = start_reg + width_x2;
            end
            OP_COPY_READ: begin
                st_re    = 1'b1;
                st_raddr = k_reg[AW-1:0];
            end
            OP_COPY_WRITE: begin
                sc_we  = 1'b1;
                k_next = (k_reg == hi_reg) ? start_reg : k_reg + ONE_C;
            end
            OP_MRG_READ: begin
                sc_re = 1'b1;
            end
            OP_MRG_WRITE: begin
                st_we    = 1'b1;
                st_waddr = k_reg[AW-1:0];
                st_wdata = take_a ? sa_reg : sb_reg;
                k_next   = k_reg + ONE_C;
                if (take_a) begin
                    a_next = a_reg + ONE_C;
                end else begin
                    b_next = b_reg + ONE_C;
                end
            end
            OP_OUT_BEGIN: begin
                k_next = '0;
            end
            OP_OUT_READ: begin
                st_re    = 1'b1;
                st_raddr = k_reg[AW-1:0];
            end
            OP_OUT_NEXT: begin
                k_next = k_reg + ONE_C;
            end
            OP_OUT_DONE: begin
                count_next    = '0;
                overflow_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        start_reg <= start_next;
        width_reg <= width_next;
        i_reg     <= i_next;
        hole_reg  <= hole_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        k_reg     <= k_next;
        held_reg  <= held_next;
    end

    // Element store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            store_rdata_reg <= store_mem[st_raddr];
        end
    end

    // Scratch copy of the segment being merged: one write, two registered reads.
    always_ff @(posedge aclk) begin
        if (sc_we) begin
            scratch_mem[k_reg[AW-1:0]] <= store_rdata_reg;
        end
        if (sc_re) begin
            sa_reg <= scratch_mem[a_reg[AW-1:0]];
            sb_reg <= scratch_mem[b_reg[AW-1:0]];
        end
    end

    always_comb begin
        status.in_last       = in_last;
        status.start_below_n = start_reg < n_reg;
        status.ins_more      = i_reg <= hi_reg;
        status.greater       = $signed(store_rdata_reg) > $signed(held_reg);
        status.hole_edge     = hole_m1 == start_reg;
        status.pass_more     = width_reg < n_reg;
        status.join_need     = mid_reg < hi_reg;
        status.k_at_hi       = k_reg == hi_reg;
        status.out_last      = k_reg == n_m1;
    end

    assign out_value   = store_rdata_reg;
    assign out_dropped = overflow_reg;

endmodule

// ===== rtl/core/hims_ctrl.sv =====
// Controller of the sorter: sequences loading, insertion runs, merge passes and output.
module hims_ctrl
    import hims_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_op_t     op
);

    typedef enum logic [15:0] {
        S_LOAD      = 16'h0001,
        S_RUN_SETUP = 16'h0002,
        S_INS_CHECK = 16'h0004,
        S_INS_HOLD  = 16'h0008,
        S_INS_CMP   = 16'h0010,
        S_INS_PLACE = 16'h0020,
        S_PASS_CHK  = 16'h0040,
        S_MRG_CHECK = 16'h0080,
        S_MRG_TEST  = 16'h0100,
        S_SEG_NEXT  = 16'h0200,
        S_COPY_RD   = 16'h0400,
        S_COPY_WR   = 16'h0800,
        S_MRG_RD    = 16'h1000,
        S_MRG_WR    = 16'h2000,
        S_OUT_RD    = 16'h4000,
        S_OUT_SHOW  = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        op         = OP_IDLE;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            S_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op = OP_LOAD;
                    if (status.in_last) begin
                        state_next = S_RUN_SETUP;
                    end
                end
            end
            S_RUN_SETUP: begin
                if (status.start_below_n) begin
                    op         = OP_RUN_BEGIN;
                    state_next = S_INS_CHECK;
                end else begin
                    op         = OP_PASS_BEGIN;
                    state_next = S_PASS_CHK;
                end
            end
            S_INS_CHECK: begin
                if (status.ins_more) begin
                    op         = OP_INS_FETCH;
                    state_next = S_INS_HOLD;
                end else begin
                    op         = OP_RUN_ADVANCE;
                    state_next = S_RUN_SETUP;
                end
            end
            S_INS_HOLD: begin
                op         = OP_INS_HOLD;
                state_next = S_INS_CMP;
            end
            S_INS_CMP: begin
                if (status.greater) begin
                    op         = OP_INS_SHIFT;
                    state_next = status.hole_edge ? S_INS_PLACE : S_INS_CMP;
                end else begin
                    op         = OP_INS_PLACE;
                    state_next = S_INS_CHECK;
                end
            end
            S_INS_PLACE: begin
                op         = OP_INS_PLACE;
                state_next = S_INS_CHECK;
            end
            S_PASS_CHK: begin
                if (status.pass_more) begin
                    state_next = S_MRG_CHECK;
                end else begin
                    op         = OP_OUT_BEGIN;
                    state_next = S_OUT_RD;
                end
            end
            S_MRG_CHECK: begin
                if (status.start_below_n) begin
                    op         = OP_MRG_BEGIN;
                    state_next = S_MRG_TEST;
                end else begin
                    op         = OP_PASS_ADVANCE;
                    state_next = S_PASS_CHK;
                end
            end
            S_MRG_TEST: begin
                state_next = status.join_need ? S_COPY_RD : S_SEG_NEXT;
            end
            S_SEG_NEXT: begin
                op         = OP_SEG_ADVANCE;
                state_next = S_MRG_CHECK;
            end
            S_COPY_RD: begin
                op         = OP_COPY_READ;
                state_next = S_COPY_WR;
            end
            S_COPY_WR: begin
                op         = OP_COPY_WRITE;
                state_next = status.k_at_hi ? S_MRG_RD : S_COPY_RD;
            end
            S_MRG_RD: begin
                op         = OP_MRG_READ;
                state_next = S_MRG_WR;
            end
            S_MRG_WR: begin
                op         = OP_MRG_WRITE;
                state_next = status.k_at_hi ? S_SEG_NEXT : S_MRG_RD;
            end
            S_OUT_RD: begin
                op         = OP_OUT_READ;
                state_next = S_OUT_SHOW;
            end
            S_OUT_SHOW: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (status.out_last) begin
                        op         = OP_OUT_DONE;
                        state_next = S_LOAD;
                    end else begin
                        op         = OP_OUT_NEXT;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/hybrid_insertion_merge_sorter.sv =====
// Top level of the batch sorter: insertion-sorted runs followed by bottom-up merges.
//
//   Channel  | Direction | tdata (low bit up)     | tlast          | tuser
//   s_       | in        | element_value [31:0]   | last_element   | -
//   m_       | out       | sorted_value  [31:0]   | last_result    | dropped_any
//
// Loading accepts one item per cycle. After the marked item the batch of n values is
// sorted: each run is insertion-sorted, then every merge pass copies each segment with a
// right half to scratch and merges it back, all bound by the single read port of the
// element store. Each result is read from the store before it is shown, and m_tready
// can hold it until it is taken.
// Reset is synchronous and clears the controller, the fill count and the drop flag.
module hybrid_insertion_merge_sorter
    import hims_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64,
    parameter int RUN_LENGTH   = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,   // element_value [31:0]
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [VALUE_W-1:0] m_tdata,   // sorted_value [31:0]
    output logic               m_tlast,
    output logic               m_tuser    // dropped_any [0]
);

    dp_op_t     dp_op;
    dp_status_t dp_status;

    hims_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (dp_status),
        .op       (dp_op)
    );

    hims_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .RUN_LENGTH   (RUN_LENGTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (dp_op),
        .in_value    (s_tdata),
        .in_last     (s_tlast),
        .status      (dp_status),
        .out_value   (m_tdata),
        .out_dropped (m_tuser)
    );

    assign m_tlast = dp_status.out_last;

    // The block never loads and emits in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output channels active together");

    // The marked item closes the load phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("still loading after the final item of a batch");

    // The final result reopens the load phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not ready for a new batch after the final result");

    // The store is written from the input only on an accepted item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_op == OP_LOAD) |-> (s_tvalid && s_tready))
        else $error("load operation without an accepted item");

endmodule

// ===== test/tb_hybrid_insertion_merge_sorter.sv =====
// Self-checking testbench for the batch sorter: directed table plus random batches.
`timescale 1ns / 1ps

module tb_hybrid_insertion_merge_sorter;
    import hims_pkg::*;

    localparam int MAX_ELEMENTS = 64;
    localparam int RUN_LENGTH   = 32;
    localparam int CLK_HALF     = 4;
    localparam int RANDOM_ITEMS = 440;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      dropped;
    } sorted_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      typed;      // expected result written in the row
        logic signed [VALUE_W-1:0] exp_value;
        logic                      exp_last;
        logic                      exp_dropped;
    } stim_row_t;

    // Single-item batches have their result typed in; the longer batches go to the predictor.
    localparam int DIRECTED_ROWS = 20;
    localparam stim_row_t DIRECTED[DIRECTED_ROWS] = '{
        '{VAL_MIN,        1'b1, 1'b1, VAL_MIN,        1'b1, 1'b0},
        '{VAL_MAX,        1'b1, 1'b1, VAL_MAX,        1'b1, 1'b0},
        '{32'sd0,         1'b1, 1'b1, 32'sd0,         1'b1, 1'b0},
        '{-32'sd1,        1'b1, 1'b1, -32'sd1,        1'b1, 1'b0},
        '{32'sd5,         1'b0, 1'b0, 32'sd0,         1'b0, 1'b0},
        '{32'sd5,         1'b0, 1'b0, 32'sd0,         1'b0, 1'b0},
        '{-32'sd3,        1'b0, 1'b0, 32'sd0,         1'b0, 1'b0},
        '{VAL_MAX,        1'b0, 1'b0, 32'sd0,         1'b0, 1'b0},
        '{VAL_MIN,        1'b0, 1'b0, 32'sd0,         1'b0, 1'b0},
        '{32'sd0,         1'b0, 1'b0, 32'sd0,         1'b0, 1'b0},
        '{-32'sd1,        1'b1, 1'b0, 32'sd0,         1'b0, 1'b0},
        '{32'sd7,         1'b0, 1'b0, 32'sd0,         1'b0, 1'b0},
        '{32'sd7,         1'b0, 1'b0, 32'sd0,         1'b0, 1'b0},
        '{32'sd7,         1'b1, 1'b0, 32'sd0,         1'b0, 1'b0},
        '{32'sd40,        1'b0, 1'b0, 32'sd0,         1'b0, 1'b0},
        '{32'sd30,        1'b0, 1'b0, 32'sd0,         1'b0, 1'b0},
        '{-32'sd20,       1'b0, 1'b0, 32'sd0,         1'b0, 1'b0},
        '{-32'sd50,       1'b1, 1'b0, 32'sd0,         1'b0, 1'b0},
        '{32'sh5555_5555, 1'b0, 1'b0, 32'sd0,         1'b0, 1'b0},
        '{32'shAAAA_AAAA, 1'b1, 1'b0, 32'sd0,         1'b0, 1'b0}
    };

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata;    // element_value [31:0]
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [VALUE_W-1:0] m_tdata;    // sorted_value [31:0]
    logic               m_tlast;
    logic               m_tuser;    // dropped_any [0]

    // Predictor state: the batch collected so far and its drop flag.
    logic signed [VALUE_W-1:0] batch_values[MAX_ELEMENTS];
    int                        batch_fill;
    bit                        batch_overflow;

    sorted_item_t sorted_expect[$];

    bit calm;
    int items_sent;
    int results_checked;
    int batches_sorted;
    int overflow_batches;
    int errors;
    int cycle_count;

    hybrid_insertion_merge_sorter #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .RUN_LENGTH  (RUN_LENGTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    // Collects one element; on the marked one, sorts the batch and queues its results.
    task automatic absorb_element(input logic signed [VALUE_W-1:0] v, input logic is_last,
                                  input bit typed, input sorted_item_t typed_item);
        logic signed [VALUE_W-1:0] held;
        int i;
        int j;
        if (batch_fill < MAX_ELEMENTS) begin
            batch_values[batch_fill] = v;
            batch_fill++;
        end else begin
            batch_overflow = 1'b1;
        end
        if (is_last) begin
            for (i = 1; i < batch_fill; i++) begin
                held = batch_values[i];
                j = i - 1;
                while (j >= 0 && batch_values[j] > held) begin
                    batch_values[j + 1] = batch_values[j];
                    j--;
                end
                batch_values[j + 1] = held;
            end
            if (typed) begin
                sorted_expect.push_back(typed_item);
            end else begin
                for (i = 0; i < batch_fill; i++)
                    sorted_expect.push_back('{batch_values[i], i == batch_fill - 1,
                                              batch_overflow});
            end
            batches_sorted++;
            if (batch_overflow)
                overflow_batches++;
            batch_fill = 0;
            batch_overflow = 1'b0;
        end
    endtask

    // Offers one item and waits for the block to take it.
    task automatic send_element(input logic signed [VALUE_W-1:0] v, input logic is_last,
                                input bit typed, input sorted_item_t typed_item);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 18) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = v;
        s_tlast  = is_last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        absorb_element(v, is_last, typed, typed_item);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            case ($urandom_range(3))
                0: pick_value = VAL_MIN;
                1: pick_value = VAL_MAX;
                2: pick_value = 32'sd0;
                default: pick_value = -32'sd1;
            endcase
        end else if (r < 40) begin
            // Narrow range so that duplicates are common.
            pick_value = $signed(32'($urandom_range(16))) - 32'sd8;
        end else begin
            pick_value = $urandom;
        end
    endfunction

    task automatic check_result();
        sorted_item_t want;
        if (sorted_expect.size() == 0) begin
            $error("unexpected result: sorted_value %0d with no expectation pending",
                   $signed(m_tdata));
            errors++;
        end else begin
            want = sorted_expect.pop_front();
            if (m_tdata !== want.value) begin
                $error("sorted_value: expected %0d, actual %0d", want.value, $signed(m_tdata));
                errors++;
            end
            if (m_tlast !== want.last) begin
                $error("last_result: expected %0b, actual %0b", want.last, m_tlast);
                errors++;
            end
            if (m_tuser !== want.dropped) begin
                $error("dropped_any: expected %0b, actual %0b", want.dropped, m_tuser);
                errors++;
            end
        end
        results_checked++;
    endtask

    // Result side: random stalls, one long hold-off, and the check of each accepted item.
    initial begin
        int  holdoff_left;
        bit  holdoff_done;
        holdoff_left = 0;
        holdoff_done = 1'b0;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (holdoff_left > 0) begin
                m_tready = 1'b0;
                holdoff_left--;
            end else if (!holdoff_done && results_checked >= 40) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLD_CYCLES;
                m_tready = 1'b0;
            end else begin
                m_tready = calm || $urandom_range(99) >= 18;
            end
            @(posedge aclk);
            if (m_tvalid && m_tready)
                check_result();
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_hybrid_insertion_merge_sorter failed");
        $finish;
    end

    initial begin
        sorted_item_t none;
        int batch_idx;
        int batch_len;
        int r;
        int k;
        none = '0;
        calm = 1'b0;
        items_sent = 0;
        results_checked = 0;
        batches_sorted = 0;
        overflow_batches = 0;
        errors = 0;
        batch_fill = 0;
        batch_overflow = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (DIRECTED[i])
            send_element(DIRECTED[i].value, DIRECTED[i].last, DIRECTED[i].typed,
                         '{DIRECTED[i].exp_value, DIRECTED[i].exp_last,
                           DIRECTED[i].exp_dropped});

        // The first random batches overflow (the marked item itself is dropped), fill
        // the store exactly, and cross one run boundary; after that sizes are random.
        batch_idx = 0;
        while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (batch_idx == 0)
                batch_len = MAX_ELEMENTS + 2;
            else if (batch_idx == 1)
                batch_len = MAX_ELEMENTS;
            else if (batch_idx == 2)
                batch_len = RUN_LENGTH + 1;
            else if (r < 60)
                batch_len = $urandom_range(8, 1);
            else if (r < 80)
                batch_len = $urandom_range(RUN_LENGTH - 1, 9);
            else if (r < 90)
                batch_len = $urandom_range(MAX_ELEMENTS - 1, RUN_LENGTH);
            else if (r < 95)
                batch_len = MAX_ELEMENTS;
            else
                batch_len = $urandom_range(MAX_ELEMENTS + 6, MAX_ELEMENTS + 1);
            calm = batch_idx >= 8 && batch_idx < 14;
            for (k = 0; k < batch_len; k++)
                send_element(pick_value(), k == batch_len - 1, 1'b0, none);
            batch_idx++;
        end
        calm = 1'b0;
        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        while (sorted_expect.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d items in %0d batches (%0d with dropped elements).",
                 items_sent, batches_sorted, overflow_batches);
        $display("Checked %0d sorted results in %0d cycles, %0d mismatches.",
                 results_checked, cycle_count, errors);
        if (errors == 0 && sorted_expect.size() == 0)
            $display("tb_hybrid_insertion_merge_sorter passed");
        else
            $display("tb_hybrid_insertion_merge_sorter failed");
        $finish;
    end

endmodule
